[sv/fps_pkg.sv]
// Shared types and constants for the five-point stencil update block.
`timescale 1ns / 1ps

package fps_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int ROW_W      = 16;
  localparam int COL_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_COLS_W = 9;
  localparam int PROD_W     = 2 * SAMPLE_W;

  localparam logic signed [SAMPLE_W-1:0] COEF_CENTER_RESET = 32'sh4000_0000;
  localparam int ROWS_RESET = 150;
  localparam int COLS_RESET = 150;
  localparam int GRID_MIN   = 3;
  localparam int AHEAD      = 3;
  localparam int FRAC_SHIFT = 30;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_CENTER = 3'd0,
    CFG_COEF_UP     = 3'd1,
    CFG_COEF_DOWN   = 3'd2,
    CFG_COEF_LEFT   = 3'd3,
    CFG_COEF_RIGHT  = 3'd4,
    CFG_ROWS        = 3'd5,
    CFG_COLS        = 3'd6
  } fps_cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] older;
    logic signed [SAMPLE_W-1:0] prev;
  } fps_pair_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [ROW_W-1:0]           row;
    logic [COL_W-1:0]           col;
    logic                       frame_end;
  } fps_res_t;

  typedef struct packed {
    logic     a_en;
    logic     b_en;
    fps_res_t a;
    fps_res_t b;
  } fps_fifo_wr_t;

endpackage

[sv/fps_cell.sv]
// Window cell: holds one column pair (row two above, row above) and weights the row-above sample.
`timescale 1ns / 1ps

module fps_cell import fps_pkg::*; (
  input  logic                       clk,
  input  logic                       shift_en,
  input  fps_pair_t                  d,
  input  logic signed [SAMPLE_W-1:0] coef,
  output fps_pair_t                  q,
  output logic signed [PROD_W-1:0]   prod
);

  fps_pair_t                pair_r;
  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      pair_r <= d;
    end
    prod_r <= $signed(pair_r.prev) * $signed(coef);
  end

  assign q    = pair_r;
  assign prod = prod_r;

endmodule

[sv/fps_line_mem.sv]
// Line memory: one column pair (row two above, row above) per entry.
`timescale 1ns / 1ps

module fps_line_mem import fps_pkg::*; #(
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  fps_pair_t        wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output fps_pair_t        rd_data
);

  fps_pair_t line_r [Depth];
  fps_pair_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= line_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/fps_out_fifo.sv]
// Result queue: up to two writes and one read per cycle.
`timescale 1ns / 1ps

module fps_out_fifo import fps_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  fps_fifo_wr_t wr,
  input  logic         rd_en,
  output logic         rd_valid,
  output fps_res_t     rd_data
);

  fps_res_t                fifo_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic [FIFO_CNT_W-1:0]   n_wr;

  assign wr_ptr_p1 = wr_ptr_r + FIFO_PTR_W'(1);
  assign n_wr      = FIFO_CNT_W'(wr.a_en) + FIFO_CNT_W'(wr.b_en);

  always_ff @(posedge clk) begin
    if (wr.a_en) begin
      fifo_r[wr_ptr_r] <= wr.a;
    end
    if (wr.b_en) begin
      fifo_r[wr.a_en ? wr_ptr_p1 : wr_ptr_r] <= wr.b;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(n_wr);
    rd_ptr_nxt = rd_en ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + n_wr - (rd_en ? FIFO_CNT_W'(1) : FIFO_CNT_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign rd_valid = (count_r != '0);
  assign rd_data  = fifo_r[rd_ptr_r];

endmodule

[sv/five_point_stencil_update.sv]
// Top level of the five-point stencil update: window chain, MAC pipeline, result queue.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_sample
//   out_     output     out_valid / out_stall  out_value, out_row, out_col, out_frame_end
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample per cycle is taken while the result queue has room; the last row yields
// two results per sample and so is limited by the single result port. A result
// passes the MAC pipeline registers m1_r to m4_r and is then written into the result
// queue, which presents it on out_. in_stall follows a registered credit count over
// the eight-entry result queue. Reset is synchronous; there is no clearing pass.
`timescale 1ns / 1ps

module five_point_stencil_update import fps_pkg::*; #(
  parameter int MAX_COLS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]  out_value,
  output logic [ROW_W-1:0]            out_row,
  output logic [COL_W-1:0]            out_col,
  output logic                        out_frame_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int ColW = $clog2(MAX_COLS);
  localparam int SumW = ColW + 2;
  localparam int ColsResetLast = ((MAX_COLS < COLS_RESET) ? MAX_COLS : COLS_RESET) - 1;
  localparam logic signed [PROD_W:0] RoundHalf = (PROD_W + 1)'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [SAMPLE_W-1:0] SatMax = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SatMin = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic                       border;
    logic signed [SAMPLE_W-1:0] centre;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ROW_W-1:0]           row_a;
    logic [ROW_W-1:0]           row_b;
    logic [COL_W-1:0]           col;
    logic                       fend;
  } fps_meta_t;

  logic signed [SAMPLE_W-1:0] coef_center_r, coef_up_r, coef_down_r, coef_left_r, coef_right_r;
  logic [ROW_W-1:0]           rows_last_r, rows_last_nxt;
  logic [ColW-1:0]            cols_last_r, cols_last_nxt;
  logic [ROW_W-1:0]           row_r, row_nxt;
  logic [ColW-1:0]            col_r, col_nxt;
  logic [ROW_W-1:0]           cfg_rows_req;
  logic [CFG_DATA_W-1:0]      cfg_cols_req, cfg_cols_clamp;
  logic                       cfg_we, cfg_restart, in_acc, out_acc, last_col, last_row;
  logic [SumW-1:0]            ahead_sum, cols_cnt;
  logic [ColW-1:0]            rd_addr;

  fps_pair_t                  wr_pair, ahead_q, right_q, centre_q, left_q;
  logic signed [PROD_W-1:0]   p_right, p_centre, p_left, p_up_r, p_down_r;

  fps_meta_t                  meta_nxt, m1_r, m2_r, m3_r, m4_r;
  logic [4:1]                 a_v_r, b_v_r;
  logic signed [PROD_W:0]     s01_r, s23_r, s4_r, u_r;
  logic signed [PROD_W+1:0]   t_r;
  logic signed [PROD_W+2:0]   sum_r;
  logic signed [PROD_W+2-FRAC_SHIFT:0] q_sh;
  logic signed [SAMPLE_W-1:0] sat_val;

  logic [1:0]                 nres;
  logic [FIFO_CNT_W-1:0]      reserved_r, reserved_nxt;
  fps_fifo_wr_t               fifo_wr;
  fps_res_t                   head;

  assign cfg_ready   = 1'b1;
  assign cfg_we      = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_we && ((cfg_index == CFG_ROWS) || (cfg_index == CFG_COLS));
  assign in_acc      = in_valid && !in_stall;
  assign out_acc     = out_valid && !out_stall;

  always_comb begin
    cfg_rows_req = cfg_data[ROW_W-1:0];
    if (cfg_rows_req < ROW_W'(GRID_MIN)) begin
      rows_last_nxt = ROW_W'(GRID_MIN - 1);
    end else begin
      rows_last_nxt = cfg_rows_req - ROW_W'(1);
    end
    cfg_cols_req = CFG_DATA_W'(cfg_data[CFG_COLS_W-1:0]);
    if (cfg_cols_req < CFG_DATA_W'(GRID_MIN)) begin
      cfg_cols_clamp = CFG_DATA_W'(GRID_MIN);
    end else if (cfg_cols_req > CFG_DATA_W'(MAX_COLS)) begin
      cfg_cols_clamp = CFG_DATA_W'(MAX_COLS);
    end else begin
      cfg_cols_clamp = cfg_cols_req;
    end
    cols_last_nxt = ColW'(cfg_cols_clamp - CFG_DATA_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_center_r <= COEF_CENTER_RESET;
      coef_up_r     <= '0;
      coef_down_r   <= '0;
      coef_left_r   <= '0;
      coef_right_r  <= '0;
      rows_last_r   <= ROW_W'(ROWS_RESET - 1);
      cols_last_r   <= ColW'(ColsResetLast);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COEF_CENTER: coef_center_r <= $signed(cfg_data);
        CFG_COEF_UP:     coef_up_r     <= $signed(cfg_data);
        CFG_COEF_DOWN:   coef_down_r   <= $signed(cfg_data);
        CFG_COEF_LEFT:   coef_left_r   <= $signed(cfg_data);
        CFG_COEF_RIGHT:  coef_right_r  <= $signed(cfg_data);
        CFG_ROWS:        rows_last_r   <= rows_last_nxt;
        CFG_COLS:        cols_last_r   <= cols_last_nxt;
        default: ;
      endcase
    end
  end

  assign last_col = (col_r == cols_last_r);
  assign last_row = (row_r == rows_last_r);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // prefetch the column three transactions ahead
  always_comb begin
    cols_cnt  = SumW'(cols_last_r) + SumW'(1);
    ahead_sum = SumW'(col_r) + SumW'(AHEAD);
    if (ahead_sum >= cols_cnt) begin
      rd_addr = ColW'(ahead_sum - cols_cnt);
    end else begin
      rd_addr = ColW'(ahead_sum);
    end
  end

  always_comb begin
    wr_pair.older = centre_q.prev;
    wr_pair.prev  = in_sample;
  end

  fps_line_mem #(.Depth(MAX_COLS)) u_line (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (col_r),
    .wr_data (wr_pair),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .rd_data (ahead_q)
  );

  fps_cell u_right (
    .clk      (clk),
    .shift_en (in_acc),
    .d        (ahead_q),
    .coef     (coef_right_r),
    .q        (right_q),
    .prod     (p_right)
  );

  fps_cell u_centre (
    .clk      (clk),
    .shift_en (in_acc),
    .d        (right_q),
    .coef     (coef_center_r),
    .q        (centre_q),
    .prod     (p_centre)
  );

  fps_cell u_left (
    .clk      (clk),
    .shift_en (in_acc),
    .d        (centre_q),
    .coef     (coef_left_r),
    .q        (left_q),
    .prod     (p_left)
  );

  always_comb begin
    meta_nxt.border = (row_r == ROW_W'(1)) || (col_r == '0) || last_col;
    meta_nxt.centre = centre_q.prev;
    meta_nxt.sample = in_sample;
    meta_nxt.row_a  = row_r - ROW_W'(1);
    meta_nxt.row_b  = row_r;
    meta_nxt.col    = COL_W'(col_r);
    meta_nxt.fend   = last_col;
  end

  always_ff @(posedge clk) begin
    p_up_r   <= $signed(centre_q.older) * $signed(coef_up_r);
    p_down_r <= $signed(in_sample) * $signed(coef_down_r);
    m1_r     <= meta_nxt;
    s01_r    <= (PROD_W + 1)'(p_centre) + (PROD_W + 1)'(p_up_r);
    s23_r    <= (PROD_W + 1)'(p_down_r) + (PROD_W + 1)'(p_left);
    s4_r     <= (PROD_W + 1)'(p_right) + RoundHalf;
    m2_r     <= m1_r;
    t_r      <= (PROD_W + 2)'(s01_r) + (PROD_W + 2)'(s23_r);
    u_r      <= s4_r;
    m3_r     <= m2_r;
    sum_r    <= (PROD_W + 3)'(t_r) + (PROD_W + 3)'(u_r);
    m4_r     <= m3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= '0;
      b_v_r <= '0;
    end else begin
      a_v_r <= {a_v_r[3:1], in_acc && (row_r != '0)};
      b_v_r <= {b_v_r[3:1], in_acc && last_row};
    end
  end

  always_comb begin
    q_sh = sum_r[PROD_W+2:FRAC_SHIFT];
    if (q_sh[PROD_W+2-FRAC_SHIFT:SAMPLE_W-1] == '0 ||
        q_sh[PROD_W+2-FRAC_SHIFT:SAMPLE_W-1] == '1) begin
      sat_val = q_sh[SAMPLE_W-1:0];
    end else if (q_sh[PROD_W+2-FRAC_SHIFT]) begin
      sat_val = SatMin;
    end else begin
      sat_val = SatMax;
    end
  end

  always_comb begin
    fifo_wr.a_en         = a_v_r[4];
    fifo_wr.b_en         = b_v_r[4];
    fifo_wr.a.value      = m4_r.border ? m4_r.centre : sat_val;
    fifo_wr.a.row        = m4_r.row_a;
    fifo_wr.a.col        = m4_r.col;
    fifo_wr.a.frame_end  = 1'b0;
    fifo_wr.b.value      = m4_r.sample;
    fifo_wr.b.row        = m4_r.row_b;
    fifo_wr.b.col        = m4_r.col;
    fifo_wr.b.frame_end  = m4_r.fend;
  end

  fps_out_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (fifo_wr),
    .rd_en    (out_acc),
    .rd_valid (out_valid),
    .rd_data  (head)
  );

  assign out_value     = head.value;
  assign out_row       = head.row;
  assign out_col       = head.col;
  assign out_frame_end = head.frame_end;

  // reserve queue space for every result still in flight
  assign nres = 2'(row_r != '0) + 2'(last_row);

  always_comb begin
    reserved_nxt = reserved_r
                 + (in_acc ? FIFO_CNT_W'(nres) : FIFO_CNT_W'(0))
                 - (out_acc ? FIFO_CNT_W'(1) : FIFO_CNT_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserved_r <= '0;
    end else begin
      reserved_r <= reserved_nxt;
    end
  end

  assign in_stall = (reserved_r > FIFO_CNT_W'(FIFO_DEPTH - 2));

  a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (reserved_r != '0))
    else $error("result presented without a reserved queue slot");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS))
      |=> (row_r == '0 && col_r == '0))
    else $error("grid size write did not restart the frame");

  a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (col_r <= cols_last_r && row_r <= rows_last_r))
    else $error("transaction accepted outside the grid");

  a_stall_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (reserved_r <= FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result credits exceed queue depth");

endmodule
